/* hw/rtl/sha1e_pkg.sv */
// Shared types, constants and round functions of the SHA-1 hash engine.
`default_nettype none

package sha1e_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_COPY
	} state_t;

	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [5:0] LAST_POS   = 6'd63;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [2:0] LAST_IDX   = 3'd4;

	// control of the byte gather and schedule shift line
	typedef struct packed {
		logic       push;
		logic       word_end;
		logic [7:0] byte_val;
		logic       step;
	} msg_ctrl_t;

	// control of the round unit and chaining words
	typedef struct packed {
		logic       load;
		logic       step;
		logic       add;
		logic       init;
		logic [6:0] rnd;
	} core_ctrl_t;

	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20) k = K_R0;
		else if (rnd < 7'd40) k = K_R1;
		else if (rnd < 7'd60) k = K_R2;
		else k = K_R3;
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < 7'd20) f = (b & c) | (~b & d);
		else if (rnd < 7'd40) f = b ^ c ^ d;
		else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
		else f = b ^ c ^ d;
		return f;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/sha1e_msg.sv */
// Byte gather into big-endian words and the 16-word message schedule shift line.
`default_nettype none

module sha1e_msg import sha1e_pkg::*; (
	input  wire logic        clk,
	input  wire msg_ctrl_t   ctrl,
	output logic [31:0]      w
);

	logic [23:0]       acc_q;
	logic [15:0][31:0] sched_q;
	logic [31:0]       mix;
	logic [31:0]       w_next;

	assign w      = sched_q[0];
	assign mix    = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
	assign w_next = {mix[30:0], mix[31]};

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			acc_q <= {acc_q[15:0], ctrl.byte_val};
			// the fourth byte closes a word: shift it in at the top
			if (ctrl.word_end) begin
				sched_q <= {{acc_q, ctrl.byte_val}, sched_q[15:1]};
			end
		end else if (ctrl.step) begin
			sched_q <= {w_next, sched_q[15:1]};
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sha1e_core.sv */
// Shared SHA-1 round unit with working variables and chaining words.
`default_nettype none

module sha1e_core import sha1e_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire core_ctrl_t  ctrl,
	input  wire logic [31:0] w,
	output logic [4:0][31:0] h
);

	logic [4:0][31:0] h_q;
	logic [31:0]      a_q, b_q, c_q, d_q, e_q;
	logic [31:0]      tmp;

	assign h   = h_q;
	assign tmp = {a_q[26:0], a_q[31:27]} + round_f(ctrl.rnd, b_q, c_q, d_q) + e_q
		+ round_k(ctrl.rnd) + w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= H_INIT;
		end else if (ctrl.init) begin
			h_q <= H_INIT;
		end else if (ctrl.add) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (ctrl.step) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sha1e_obuf.sv */
// Digest output buffer: holds five words and streams them out in order.
`default_nettype none

module sha1e_obuf import sha1e_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic [4:0][31:0] words,
	input  wire logic             ready,
	output logic                  valid,
	output logic [31:0]           data,
	output logic [2:0]            idx,
	output logic                  last
);

	logic [4:0][31:0] words_q;
	logic             busy_q;
	logic [2:0]       idx_q;

	assign valid = busy_q;
	assign data  = words_q[idx_q];
	assign idx   = idx_q;
	assign last  = (idx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && ready) begin
			if (idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			words_q <= words;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sha1_hash_engine.sv */
// SHA-1 hash engine top level: sequencer, padding and length insertion.
// A message byte that does not close a 64-byte block is taken while the engine is idle.
// A byte that closes a block holds the input while the 80 rounds run on the one
// shared round unit and the chaining words are updated.
// End of message: pad bytes up to the end of the block, a second padded block when
// the length does not fit, rounds and chaining update per final block, a copy step
// (held until the previous digest drains), then the five digest words at one per
// cycle while m_tready is high. Reset restores the initial chaining words and clears counts; schedule is not reset.
`default_nettype none

module sha1_hash_engine import sha1e_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tuser,   // [0] byte_valid
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [31:0] digest_word
	output logic [2:0]       m_tuser,   // [2:0] word_index
	output logic             m_tlast
);

	state_t           state_q, state_nxt;
	logic [5:0]       ptr_q;
	logic [60:0]      cnt_q;
	logic [63:0]      len_q;
	logic [6:0]       rnd_q;
	logic             fin_q, first_q, lenblk_q;
	logic             accept;
	logic             len_byte;
	logic [7:0]       pad_byte;
	logic             obuf_load;
	msg_ctrl_t        mctl;
	core_ctrl_t       cctl;
	logic [31:0]      w;
	logic [4:0][31:0] h;

	assign accept   = s_tvalid && s_tready;
	assign len_byte = lenblk_q && !first_q && (ptr_q >= LEN_POS);
	assign pad_byte = first_q ? PAD_MARK : (len_byte ? len_q[63:56] : 8'h00);

	always_comb begin
		state_nxt     = state_q;
		s_tready      = 1'b0;
		obuf_load     = 1'b0;
		mctl          = '0;
		cctl          = '0;
		cctl.rnd      = rnd_q;
		mctl.word_end = (ptr_q[1:0] == 2'd3);
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser) begin
						mctl.push     = 1'b1;
						mctl.byte_val = s_tdata;
					end
					if (s_tuser && (ptr_q == LAST_POS)) begin
						state_nxt = ST_ROUND;
						cctl.load = 1'b1;
					end else if (s_tlast) begin
						state_nxt = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				mctl.push     = 1'b1;
				mctl.byte_val = pad_byte;
				if (ptr_q == LAST_POS) begin
					state_nxt = ST_ROUND;
					cctl.load = 1'b1;
				end
			end
			ST_ROUND: begin
				cctl.step = 1'b1;
				mctl.step = 1'b1;
				if (rnd_q == LAST_ROUND) state_nxt = ST_ADD;
			end
			ST_ADD: begin
				cctl.add = 1'b1;
				if (!fin_q) state_nxt = ST_IDLE;
				else if (lenblk_q) state_nxt = ST_COPY;
				else state_nxt = ST_PAD;
			end
			ST_COPY: begin
				// wait until the previous digest has drained
				if (!m_tvalid) begin
					obuf_load = 1'b1;
					cctl.init = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ptr_q    <= '0;
			cnt_q    <= '0;
			rnd_q    <= '0;
			fin_q    <= 1'b0;
			first_q  <= 1'b0;
			lenblk_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser) begin
						ptr_q <= ptr_q + 6'd1;
						cnt_q <= cnt_q + 61'd1;
					end
					if (accept && s_tlast) begin
						fin_q   <= 1'b1;
						first_q <= 1'b1;
					end
				end
				ST_PAD: begin
					ptr_q   <= ptr_q + 6'd1;
					first_q <= 1'b0;
					// mark below the length field: length goes in this block
					if (first_q && (ptr_q < LEN_POS)) lenblk_q <= 1'b1;
				end
				ST_ROUND: begin
					rnd_q <= (rnd_q == LAST_ROUND) ? 7'd0 : rnd_q + 7'd1;
				end
				ST_ADD: begin
					// mark fell into the length field: length goes in the next block
					if (fin_q && !lenblk_q && !first_q) lenblk_q <= 1'b1;
				end
				ST_COPY: begin
					if (!m_tvalid) begin
						ptr_q    <= '0;
						cnt_q    <= '0;
						fin_q    <= 1'b0;
						first_q  <= 1'b0;
						lenblk_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			len_q <= {cnt_q + {60'd0, s_tuser}, 3'b000};
		end else if ((state_q == ST_PAD) && len_byte) begin
			len_q <= {len_q[55:0], 8'h00};
		end
	end

	sha1e_msg u_msg (
		.clk  (clk),
		.ctrl (mctl),
		.w    (w)
	);

	sha1e_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cctl),
		.w      (w),
		.h      (h)
	);

	sha1e_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (obuf_load),
		.words  (h),
		.ready  (m_tready),
		.valid  (m_tvalid),
		.data   (m_tdata),
		.idx    (m_tuser),
		.last   (m_tlast)
	);

endmodule

`default_nettype wire

/* hw/rtl/sha1e_check.sv */
// Port-level checker for the SHA-1 hash engine, bound to the top level.
`default_nettype none

module sha1e_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [7:0]  s_tdata,
	input wire logic        s_tuser,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata,
	input wire logic [2:0]  m_tuser,
	input wire logic        m_tlast
);

	// the last word is always the fifth
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == 3'd4)))
		else $error("last word flag does not match word index");

	// end of message starts padding or the rounds of a full block, so input must stall
	a_eom_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input ready right after end of message");

	// digest words advance by one after each taken item
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=>
			(m_tvalid && (m_tuser == $past(m_tuser) + 3'd1)))
		else $error("digest word index did not advance");

	// a finished digest is not followed by another in the next cycle
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("output valid right after last word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled output item changed");

endmodule

bind sha1_hash_engine sha1e_check u_check (.*);

`default_nettype wire
